FILE: rtl/core/frtr_pkg.sv
// Shared types and constants for the fourth-rank tensor rotation unit.
package frtr_pkg;

   // Defaults for the top-level parameters
   localparam int SPACE_DIM_DEF = 3;
   localparam int ROT_FRAC_DEF  = 14;

   // Fixed field widths
   localparam int MODE_W   = 2;
   localparam int INDEX_W  = 2;
   localparam int ROT_W    = 16;
   localparam int TENSOR_W = 32;
   localparam int RESULT_W = 32;

   // Request codes
   localparam logic [MODE_W-1:0] MODE_LOAD_ROT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD_TEN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY    = 2'd2;

   // Datapath widths: rotation pair product, four-way product, single term, accumulator.
   // Sized for the largest space (256 terms of at most 2^91 each).
   localparam int PAIR_W = 2 * ROT_W;
   localparam int PROD_W = 62;
   localparam int LO_W   = 32;
   localparam int HI_W   = PROD_W - LO_W;
   localparam int TERM_W = PROD_W + TENSOR_W;
   localparam int ACC_W  = 104;

   localparam logic [RESULT_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [RESULT_W-1:0] SAT_MIN = 32'h8000_0000;

   typedef struct packed {
      logic clear;       // zero the accumulator
      logic term_valid;  // rotation heads valid this cycle, tensor word next cycle
   } mac_ctrl_type;

endpackage

FILE: rtl/core/frtr_store.sv
// Synchronous single-port-write, registered-read store that reads zero until written.
module frtr_store #(
   parameter int WIDTH = frtr_pkg::TENSOR_W,
   parameter int DEPTH = frtr_pkg::SPACE_DIM_DEF ** 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] written_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_written_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // per-entry written flags stand in for clearing the array at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         rd_written_ff <= written_ff[rd_addr];
      end
   end

   assign rd_data = rd_written_ff ? rd_data_ff : '0;

endmodule

FILE: rtl/core/frtr_mac.sv
// Pipelined four-way product times tensor entry, with wide accumulator.
module frtr_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  frtr_pkg::mac_ctrl_type                ctrl,
   input  logic signed [frtr_pkg::ROT_W-1:0]     rot_i,
   input  logic signed [frtr_pkg::ROT_W-1:0]     rot_j,
   input  logic signed [frtr_pkg::ROT_W-1:0]     rot_k,
   input  logic signed [frtr_pkg::ROT_W-1:0]     rot_l,
   input  logic signed [frtr_pkg::TENSOR_W-1:0]  tensor,
   output logic signed [frtr_pkg::ACC_W-1:0]     acc,
   output logic                                  busy
);

   localparam int PAIR_W   = frtr_pkg::PAIR_W;
   localparam int PROD_W   = frtr_pkg::PROD_W;
   localparam int LO_W     = frtr_pkg::LO_W;
   localparam int HI_W     = frtr_pkg::HI_W;
   localparam int TENSOR_W = frtr_pkg::TENSOR_W;
   localparam int TERM_W   = frtr_pkg::TERM_W;
   localparam int ACC_W    = frtr_pkg::ACC_W;
   localparam int HIP_W    = HI_W + TENSOR_W;
   localparam int LOP_W    = LO_W + 1 + TENSOR_W;

   // stage 1: rotation pair products
   logic signed [PAIR_W-1:0]   p1_ff, p2_ff;
   logic                       v1_ff;
   // stage 2: four-way product, tensor word aligned
   logic signed [2*PAIR_W-1:0] p_full;
   logic        [PROD_W-1:0]   p_ff;
   logic signed [TENSOR_W-1:0] c_ff;
   logic                       v2_ff;
   // stage 3: split partial products
   logic signed [HIP_W-1:0]    hi_prod_ff;
   logic signed [LOP_W-1:0]    lo_prod_ff;
   logic                       v3_ff;
   // stage 4: recombined term
   logic signed [TERM_W-1:0]   term_ff;
   logic signed [TERM_W-1:0]   term_in;
   logic                       v4_ff;
   logic signed [ACC_W-1:0]    acc_ff;

   assign p_full  = p1_ff * p2_ff;
   assign term_in = $signed({hi_prod_ff, {LO_W{1'b0}}})
                  + $signed({{(TERM_W-LOP_W){lo_prod_ff[LOP_W-1]}}, lo_prod_ff});

   always_ff @(posedge clock) begin
      p1_ff      <= rot_i * rot_j;
      p2_ff      <= rot_k * rot_l;
      p_ff       <= p_full[PROD_W-1:0];
      c_ff       <= tensor;
      hi_prod_ff <= $signed(p_ff[PROD_W-1:LO_W]) * c_ff;
      lo_prod_ff <= $signed({1'b0, p_ff[LO_W-1:0]}) * c_ff;
      term_ff    <= term_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         acc_ff <= '0;
      end else begin
         v1_ff <= ctrl.term_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         if (ctrl.clear) begin
            acc_ff <= '0;
         end else if (v4_ff) begin
            acc_ff <= acc_ff + {{(ACC_W-TERM_W){term_ff[TERM_W-1]}}, term_ff};
         end
      end
   end

   assign acc  = acc_ff;
   assign busy = v1_ff | v2_ff | v3_ff | v4_ff;

endmodule

FILE: rtl/core/fourth_rank_tensor_rotation_unit.sv
// Fourth-rank tensor rotation unit: holds a SPACE_DIM x SPACE_DIM rotation
// matrix O (signed, ROTATION_FRAC_BITS fraction bits) and a SPACE_DIM^4
// tensor C of signed 32-bit words, both zero after reset. Mode 0 writes one
// entry of O, mode 1 one entry of C; neither gives a response. Mode 2 returns
// C'[i][j][k][l] = sum O[i][a]O[j][b]O[k][c]O[l][d] C[a][b][c][d], summed
// exactly, shifted right by 4*ROTATION_FRAC_BITS with flooring, saturated to
// 32 bits with an overflow flag. A query first copies the four needed rows of
// O out of the rotation store through its single read port, then one tensor
// word per cycle streams out of the tensor store into the MAC pipeline,
// followed by a drain of that pipeline. A query with an index beyond the
// space answers zero without the copy or the stream. Mode 3 and out-of-range
// loads are dropped. Requests are held off while a query runs; loads are
// taken while a response waits on rsp_stall.
module fourth_rank_tensor_rotation_unit #(
   parameter int SPACE_DIM          = frtr_pkg::SPACE_DIM_DEF,
   parameter int ROTATION_FRAC_BITS = frtr_pkg::ROT_FRAC_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [frtr_pkg::MODE_W-1:0]          req_mode,
   input  logic [frtr_pkg::INDEX_W-1:0]         req_index_i,
   input  logic [frtr_pkg::INDEX_W-1:0]         req_index_j,
   input  logic [frtr_pkg::INDEX_W-1:0]         req_index_k,
   input  logic [frtr_pkg::INDEX_W-1:0]         req_index_l,
   input  logic signed [frtr_pkg::ROT_W-1:0]    req_rotation_value,
   input  logic signed [frtr_pkg::TENSOR_W-1:0] req_tensor_value,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [frtr_pkg::RESULT_W-1:0] rsp_rotated_value,
   output logic                                 rsp_overflow
);

   localparam int ROT_DEPTH = SPACE_DIM * SPACE_DIM;
   localparam int TEN_DEPTH = ROT_DEPTH * ROT_DEPTH;
   localparam int ROT_AW    = $clog2(ROT_DEPTH);
   localparam int TEN_AW    = $clog2(TEN_DEPTH);
   localparam int DIG_W     = $clog2(SPACE_DIM);
   localparam int SHIFT     = 4 * ROTATION_FRAC_BITS;
   localparam int ROT_W     = frtr_pkg::ROT_W;
   localparam int TENSOR_W  = frtr_pkg::TENSOR_W;
   localparam int INDEX_W   = frtr_pkg::INDEX_W;
   localparam int ACC_W     = frtr_pkg::ACC_W;
   localparam int RESULT_W  = frtr_pkg::RESULT_W;
   localparam int NUM_ROWS  = 4;

   localparam logic [DIG_W-1:0]  DIG_LAST  = DIG_W'(SPACE_DIM - 1);
   localparam logic [TEN_AW-1:0] TERM_LAST = TEN_AW'(TEN_DEPTH - 1);
   localparam logic [1:0]        ROW_LAST  = 2'(NUM_ROWS - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FETCH  = 3'd1;  // copy rows of O
   localparam logic [2:0] ST_SETTLE = 3'd2;  // last row word lands
   localparam logic [2:0] ST_RUN    = 3'd3;  // stream tensor terms
   localparam logic [2:0] ST_DRAIN  = 3'd4;  // empty the MAC pipeline
   localparam logic [2:0] ST_DONE   = 3'd5;  // hand result to output register

   logic [2:0] state_ff, state_in;

   // captured query indices
   logic [INDEX_W-1:0] idx_ff [NUM_ROWS];

   // row fetch
   logic [1:0]       frow_ff, frow_in;
   logic [DIG_W-1:0] fcol_ff, fcol_in;
   logic             fdata_ff, fdata_in;   // rotation read data arrives this cycle
   logic [1:0]       fdrow_ff;             // row that the arriving word belongs to

   // local copies of rows i, j, k, l of O; element 0 is the current column
   logic signed [ROT_W-1:0] rows_ff [NUM_ROWS][SPACE_DIM];

   // term sequencing
   logic [TEN_AW-1:0] term_ff, term_in;
   logic [DIG_W-1:0]  dig_d_ff, dig_c_ff, dig_b_ff;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [RESULT_W-1:0] rsp_value_ff;
   logic                       rsp_ovf_ff;
   logic                       rsp_load;

   logic accept;
   logic idx_i_ok, idx_j_ok, idx_k_ok, idx_l_ok;

   // stores
   logic                    rot_wr_en;
   logic [ROT_AW-1:0]       rot_wr_addr, rot_rd_addr;
   logic [ROT_W-1:0]        rot_rd_data;
   logic [INDEX_W-1:0]      fetch_idx;
   logic                    ten_wr_en;
   logic [TEN_AW-1:0]       ten_wr_addr;
   logic [TENSOR_W-1:0]     ten_rd_data;

   // MAC
   frtr_pkg::mac_ctrl_type  mac_ctrl;
   logic signed [ACC_W-1:0] mac_acc;
   logic                    mac_busy;

   // result formatting
   logic signed [ACC_W-1:0]        acc_shr;
   logic [ACC_W-RESULT_W:0]        acc_top;
   logic                           acc_fits;
   logic signed [RESULT_W-1:0]     sat_value;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   assign idx_i_ok = 32'(req_index_i) < SPACE_DIM;
   assign idx_j_ok = 32'(req_index_j) < SPACE_DIM;
   assign idx_k_ok = 32'(req_index_k) < SPACE_DIM;
   assign idx_l_ok = 32'(req_index_l) < SPACE_DIM;

   // ---------------- stores ----------------
   assign rot_wr_en   = accept && (req_mode == frtr_pkg::MODE_LOAD_ROT) && idx_i_ok && idx_j_ok;
   assign rot_wr_addr = ROT_AW'(32'(req_index_i) * SPACE_DIM + 32'(req_index_j));
   assign fetch_idx   = idx_ff[frow_ff];
   assign rot_rd_addr = ROT_AW'(32'(fetch_idx) * SPACE_DIM + 32'(fcol_ff));

   assign ten_wr_en   = accept && (req_mode == frtr_pkg::MODE_LOAD_TEN)
                      && idx_i_ok && idx_j_ok && idx_k_ok && idx_l_ok;
   assign ten_wr_addr = TEN_AW'(((32'(req_index_i) * SPACE_DIM + 32'(req_index_j)) * SPACE_DIM
                               + 32'(req_index_k)) * SPACE_DIM + 32'(req_index_l));

   frtr_store #(
      .WIDTH (ROT_W),
      .DEPTH (ROT_DEPTH)
   ) u_rot_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rot_wr_en),
      .wr_addr (rot_wr_addr),
      .wr_data (req_rotation_value),
      .rd_addr (rot_rd_addr),
      .rd_data (rot_rd_data)
   );

   frtr_store #(
      .WIDTH (TENSOR_W),
      .DEPTH (TEN_DEPTH)
   ) u_ten_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ten_wr_en),
      .wr_addr (ten_wr_addr),
      .wr_data (req_tensor_value),
      .rd_addr (term_ff),
      .rd_data (ten_rd_data)
   );

   // ---------------- MAC ----------------
   always_comb begin
      mac_ctrl.clear      = accept && (req_mode == frtr_pkg::MODE_QUERY);
      mac_ctrl.term_valid = (state_ff == ST_RUN);
   end

   frtr_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .rot_i  (rows_ff[0][0]),
      .rot_j  (rows_ff[1][0]),
      .rot_k  (rows_ff[2][0]),
      .rot_l  (rows_ff[3][0]),
      .tensor ($signed(ten_rd_data)),
      .acc    (mac_acc),
      .busy   (mac_busy)
   );

   // ---------------- control ----------------
   always_comb begin
      state_in     = state_ff;
      frow_in      = frow_ff;
      fcol_in      = fcol_ff;
      fdata_in     = 1'b0;
      term_in      = term_ff;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == frtr_pkg::MODE_QUERY)) begin
               frow_in = '0;
               fcol_in = '0;
               term_in = '0;
               // bad index: accumulator just cleared, so the answer is zero
               if (idx_i_ok && idx_j_ok && idx_k_ok && idx_l_ok) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_FETCH: begin
            fdata_in = 1'b1;
            if (fcol_ff == DIG_LAST) begin
               fcol_in = '0;
               frow_in = frow_ff + 2'd1;
               if (frow_ff == ROW_LAST) begin
                  state_in = ST_SETTLE;
               end
            end else begin
               fcol_in = fcol_ff + DIG_W'(1);
            end
         end
         ST_SETTLE: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            term_in = term_ff + TEN_AW'(1);
            if (term_ff == TERM_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!mac_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fdata_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fdata_ff <= fdata_in;
      end
   end

   always_ff @(posedge clock) begin
      frow_ff  <= frow_in;
      fcol_ff  <= fcol_in;
      fdrow_ff <= frow_ff;
      term_ff  <= term_in;
      if (accept && (req_mode == frtr_pkg::MODE_QUERY)) begin
         idx_ff[0] <= req_index_i;
         idx_ff[1] <= req_index_j;
         idx_ff[2] <= req_index_k;
         idx_ff[3] <= req_index_l;
      end
   end

   // term digits (d fastest); rows rotate so element 0 tracks the digit
   always_ff @(posedge clock) begin
      if (state_ff == ST_SETTLE) begin
         dig_d_ff <= '0;
         dig_c_ff <= '0;
         dig_b_ff <= '0;
      end else if (state_ff == ST_RUN) begin
         dig_d_ff <= (dig_d_ff == DIG_LAST) ? '0 : dig_d_ff + DIG_W'(1);
         if (dig_d_ff == DIG_LAST) begin
            dig_c_ff <= (dig_c_ff == DIG_LAST) ? '0 : dig_c_ff + DIG_W'(1);
            if (dig_c_ff == DIG_LAST) begin
               dig_b_ff <= (dig_b_ff == DIG_LAST) ? '0 : dig_b_ff + DIG_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fdata_ff) begin
         // shift in from the top; after SPACE_DIM words column 0 sits at element 0
         rows_ff[fdrow_ff][SPACE_DIM-1] <= $signed(rot_rd_data);
         for (int m = 0; m < SPACE_DIM - 1; m++) begin
            rows_ff[fdrow_ff][m] <= rows_ff[fdrow_ff][m+1];
         end
      end else if (state_ff == ST_RUN) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            if ((r == 3)
                || ((r == 2) && (dig_d_ff == DIG_LAST))
                || ((r == 1) && (dig_d_ff == DIG_LAST) && (dig_c_ff == DIG_LAST))
                || ((r == 0) && (dig_d_ff == DIG_LAST) && (dig_c_ff == DIG_LAST)
                             && (dig_b_ff == DIG_LAST))) begin
               rows_ff[r][SPACE_DIM-1] <= rows_ff[r][0];
               for (int m = 0; m < SPACE_DIM - 1; m++) begin
                  rows_ff[r][m] <= rows_ff[r][m+1];
               end
            end
         end
      end
   end

   // ---------------- result: floor shift, saturate ----------------
   assign acc_shr   = mac_acc >>> SHIFT;
   assign acc_top   = acc_shr[ACC_W-1:RESULT_W-1];
   assign acc_fits  = (&acc_top) || !(|acc_top);
   assign sat_value = acc_fits ? acc_shr[RESULT_W-1:0]
                    : (mac_acc[ACC_W-1] ? frtr_pkg::SAT_MIN : frtr_pkg::SAT_MAX);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff <= sat_value;
         rsp_ovf_ff   <= !acc_fits;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rotated_value = rsp_value_ff;
   assign rsp_overflow      = rsp_ovf_ff;

endmodule
